// ===== src/assert_macros.svh =====
// Assertion macros shared by the RTL files.
// Depends on nothing; included by modules that check their own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every rising edge outside reset.
`define CHK_IMPL(label, clk, rst, a, c, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) else $error(msg);
// Next-cycle implication outside reset.
`define CHK_NEXT(label, clk, rst, a, c, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) else $error(msg);
`endif

// ===== src/htnm_pkg.sv =====
// Shared types, constants and widths for the height to normal map block.
// No dependencies.
package htnm_pkg;
  localparam int MaxWidthDef = 1024;
  localparam int SlopeW = 24;
  localparam int GainW = 24;

  typedef enum logic [1:0] {
    REG_WIDTH  = 2'd0,
    REG_HEIGHT = 2'd1,
    REG_GAIN_X = 2'd2,
    REG_GAIN_Y = 2'd3
  } reg_idx_t;

  // Neighbour set handed from the line-store front end to the math pipe.
  typedef struct packed {
    logic       valid;
    logic [7:0] left;
    logic [7:0] right;
    logic [7:0] above;
    logic [7:0] below;
    logic       last;
  } nbr_t;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_RUN  = 3'b010,
    ST_OUT  = 3'b100
  } math_state_t;
endpackage

// ===== src/height_to_normal_map.sv =====
// Channel | dir | contents
// s_axis  | in  | tdata: height_value[7:0]; tuser: func
// m_axis  | out | tdata: red, green, blue; tlast: frame_end
// apb     | in  | width, height, gain_x, gain_y at 0,4,8,12
// An ignored item is only accepted; a stored pixel with no word passes accept
// and the line-store phases ph 1, 2 and 3. An item that makes a word then goes
// through store, latch, setup, divide, root, encode and the output register
// before the next accept. Reset is synchronous; the
// line stores are not cleared. Input stalls while the math is busy; a word
// waiting on m_axis stalls the math only once the next word is done behind it.
module height_to_normal_map #(
  parameter int MAX_WIDTH = htnm_pkg::MaxWidthDef
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // height_value[7:0]
  input  logic        s_axis_tuser,   // func
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // red[7:0], green[15:8], blue[23:16]
  output logic        m_axis_tlast,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import htnm_pkg::*;
  localparam int AW = $clog2(MAX_WIDTH);

  logic [10:0] image_width;
  logic [15:0] image_height;
  logic [23:0] gain_x, gain_y;
  logic [7:0] row_above [MAX_WIDTH];
  logic [7:0] row_center [MAX_WIDTH];
  logic [AW-1:0] column_count, drain_count, ra_addr, rc_addr;
  logic [15:0] row_count;
  logic [7:0] ra_q, rc_q;
  logic [1:0] ph;
  logic func_q;
  logic [7:0] hv_q, c_v, l_v, c_prev;
  logic [AW-1:0] col_q;
  nbr_t nbr;
  logic busy, res_valid;
  logic [7:0] red, green, blue;
  logic res_last;
  logic [11:0] w_eff;
  logic [15:0] h_eff;
  logic wr_en;
  logic [AW-1:0] cur;
  logic [11:0] cur_ext;

  assign pready = 1'b1;
  assign wr_en = psel && penable && pwrite;
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width <= 11'd1024; image_height <= 16'd1024;
      gain_x <= 24'd655; gain_y <= 24'd655;
    end else if (wr_en) begin
      unique case (reg_idx_t'(paddr[3:2]))
        REG_WIDTH:  image_width <= pwdata[10:0];
        REG_HEIGHT: image_height <= pwdata[15:0];
        REG_GAIN_X: gain_x <= pwdata[23:0];
        REG_GAIN_Y: gain_y <= pwdata[23:0];
        default: ;
      endcase
    end
  end
  always_comb begin
    unique case (reg_idx_t'(paddr[3:2]))
      REG_WIDTH:  prdata = 32'(image_width);
      REG_HEIGHT: prdata = 32'(image_height);
      REG_GAIN_X: prdata = 32'(gain_x);
      REG_GAIN_Y: prdata = 32'(gain_y);
      default: prdata = 32'd0;
    endcase
  end

  always_comb begin
    w_eff = (image_width == 11'd0) ? 12'd1 :
            (32'(image_width) > MAX_WIDTH) ? 12'(MAX_WIDTH) : 12'(image_width);
    h_eff = (image_height == 16'd0) ? 16'd1 : image_height;
  end

  // ph 0 accept, 1 read center/above at col, 2 read left/right neighbors.
  assign s_axis_tready = !rst && (ph == 2'd0) && !busy && !nbr.valid;
  wire acc = s_axis_tvalid && s_axis_tready;
  wire drain_mode = row_count >= h_eff;
  always_comb begin
    cur = drain_mode ? drain_count : column_count;
    if (32'(cur) >= 32'(w_eff)) cur = AW'(w_eff - 12'd1);
    cur_ext = 12'(cur);
  end

  always_ff @(posedge clk) begin
    ra_q <= row_above[ra_addr];
    rc_q <= row_center[rc_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ph <= 2'd0; column_count <= '0; drain_count <= '0; row_count <= '0;
      nbr.valid <= 1'b0;
    end else begin
      case (ph)
        2'd0: begin
          nbr.valid <= 1'b0;
          if (acc) begin
            func_q <= s_axis_tuser; hv_q <= s_axis_tdata; col_q <= cur;
            if (s_axis_tuser == drain_mode) begin
              ra_addr <= cur; rc_addr <= cur; ph <= 2'd1;
            end
          end
        end
        2'd1: begin
          // center and above arrive next; set up left and right
          nbr.valid <= 1'b0;
          ra_addr <= (col_q == '0) ? col_q : col_q - AW'(1);
          rc_addr <= (cur_ext + 12'd1 < w_eff) ? col_q + AW'(1) : col_q;
          ph <= 2'd2;
        end
        2'd2: begin
          nbr.valid <= 1'b0;
          c_v <= rc_q; l_v <= ra_q; ph <= 2'd3;
        end
        default: begin
          ph <= 2'd0;
          if (!func_q) begin
            nbr.left <= (col_q == '0) ? c_v : ra_q;
            nbr.right <= (cur_ext + 12'd1 < w_eff) ? rc_q : c_v;
            nbr.above <= (row_count >= 16'd2) ? l_v : c_v;
            nbr.below <= hv_q; nbr.last <= 1'b0;
            nbr.valid <= row_count >= 16'd1;
            row_above[col_q] <= c_v; row_center[col_q] <= hv_q;
            if (cur_ext + 12'd1 >= w_eff) begin
              column_count <= '0; row_count <= row_count + 16'd1;
            end else column_count <= col_q + AW'(1);
          end else begin
            nbr.valid <= 1'b1;
            nbr.below <= c_v; nbr.right <= rc_q; nbr.above <= (h_eff >= 16'd2) ? l_v : c_v;
            // drains run left to right: the left neighbor is the last drain's center
            nbr.left <= (col_q == '0) ? c_v : c_prev;
            c_prev <= c_v;
            nbr.last <= cur_ext + 12'd1 >= w_eff;
            if (cur_ext + 12'd1 >= w_eff) begin
              column_count <= '0; row_count <= '0; drain_count <= '0;
            end else drain_count <= col_q + AW'(1);
          end
        end
      endcase
    end
  end

  htnm_math u_math (
    .clk(clk), .rst(rst), .nbr(nbr), .gain_x(gain_x), .gain_y(gain_y),
    .busy(busy), .res_valid(res_valid), .res_take(m_axis_tready),
    .red(red), .green(green), .blue(blue), .res_last(res_last)
  );

  assign m_axis_tvalid = res_valid;
  assign m_axis_tdata = {blue, green, red};
  assign m_axis_tlast = res_last;

  `include "assert_macros.svh"
  `CHK_IMPL(a_no_accept_busy, clk, rst, acc, !busy, "accept while busy")
  `CHK_IMPL(a_ph_ready, clk, rst, ph != 2'd0, !s_axis_tready, "ready mid-access")
  `CHK_NEXT(a_stall_hold, clk, rst, m_axis_tvalid && !m_axis_tready, m_axis_tvalid, "lost")
endmodule

// ===== src/htnm_math.sv =====
// Normal vector math: slopes, squared norm, inverse norm by a bit-serial
// square root of a restoring quotient, and channel encoding. Uses htnm_pkg.
module htnm_math (
  input  logic                 clk,
  input  logic                 rst,
  input  htnm_pkg::nbr_t       nbr,
  input  logic [23:0]          gain_x,
  input  logic [23:0]          gain_y,
  output logic                 busy,
  output logic                 res_valid,
  input  logic                 res_take,
  output logic [7:0]           red,
  output logic [7:0]           green,
  output logic [7:0]           blue,
  output logic                 res_last
);
  import htnm_pkg::*;

  // ceil(2^38 / 255): exact floor quotient for dividends below 2^30.
  localparam logic [30:0] Recip255 = 31'd1077952577;

  math_state_t state;
  logic [5:0] step;
  logic [2:0] phase;
  logic signed [SlopeW-1:0] sx, sy;
  logic [60:0] px, py;
  logic [47:0] ax2, ay2;
  logic [60:0] quo;
  logic [60:0] rem;
  logic [60:0] nrm;
  logic [63:0] sq_v, sq_res, sq_bit;
  logic [31:0] mdx, mdy;
  logic        ngx, ngy;
  logic last_q;
  logic [16:0] inv;
  logic [7:0] r_q, g_q, b_q;
  logic       out_load;
  logic       o_valid;
  logic       o_last;
  logic [7:0] o_red, o_green, o_blue;

  function automatic logic [7:0] enc(input logic signed [SlopeW-1:0] s,
                                     input logic [16:0] iv);
    logic signed [43:0] p;
    logic signed [44:0] v;
    logic [40:0] c;
    p = 44'(s) * $signed({1'b0, iv});
    v = 45'sd1073741824 - 45'(p);
    if (v < 0) v = 0;
    if (v > 45'sd2147483648) v = 45'sd2147483648;
    c = (41'(v[31:0]) * 41'd255) >> 31;
    enc = (c > 41'd255) ? 8'd255 : c[7:0];
  endfunction

  assign out_load = (state == ST_OUT) && (!o_valid || res_take);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (nbr.valid) begin
            mdx <= 32'(gain_x) * 32'(nbr.right > nbr.left ? nbr.right - nbr.left
                                                            : nbr.left - nbr.right);
            ngx <= nbr.right < nbr.left;
            mdy <= 32'(gain_y) * 32'(nbr.above > nbr.below ? nbr.above - nbr.below
                                                            : nbr.below - nbr.above);
            ngy <= nbr.above < nbr.below;
            last_q <= nbr.last;
            phase <= 3'd0;
            state <= ST_RUN;
          end
        end
        ST_RUN: begin
          // Phase 0 scale by 1/1020, 1 slopes and squares, 2 sum, 3 divide,
          // 4 root, 5 and 6 encode.
          case (phase)
            3'd0: begin
              // x/1020 = (x/4)/255, the /255 as a reciprocal multiply
              px <= 61'(30'((mdx + 32'd510) >> 2)) * 61'(Recip255);
              py <= 61'(30'((mdy + 32'd510) >> 2)) * 61'(Recip255);
              phase <= 3'd1;
            end
            3'd1: begin
              sx <= ngx ? -SlopeW'(px[60:38]) : SlopeW'(px[60:38]);
              sy <= ngy ? -SlopeW'(py[60:38]) : SlopeW'(py[60:38]);
              ax2 <= 48'(px[60:38]) * 48'(px[60:38]);
              ay2 <= 48'(py[60:38]) * 48'(py[60:38]);
              phase <= 3'd2;
            end
            3'd2: begin
              nrm <= 61'd268435456 + 61'(ax2) + 61'(ay2);
              rem <= 61'd0;
              quo <= 61'd0;
              step <= 6'd60;
              phase <= 3'd3;
            end
            3'd3: begin
              // Restoring division of 2^60 by the norm, one bit per cycle.
              if ({rem[59:0], (step == 6'd60)} >= nrm) begin
                rem <= {rem[59:0], (step == 6'd60)} - nrm;
                quo <= {quo[59:0], 1'b1};
              end else begin
                rem <= {rem[59:0], (step == 6'd60)};
                quo <= {quo[59:0], 1'b0};
              end
              if (step == 6'd0) begin
                phase <= 3'd4;
                step <= 6'd31;
                sq_res <= 64'd0;
                sq_bit <= 64'h4000_0000_0000_0000;
              end else begin
                step <= step - 6'd1;
              end
              if (step == 6'd0) sq_v <= 64'({quo[59:0], 1'b0}) |
                ((({rem[59:0], 1'b0} >= nrm) ? 64'd1 : 64'd0));
            end
            3'd4: begin
              // Digit-by-digit square root, one result bit per cycle.
              if (sq_v >= sq_res + sq_bit) begin
                sq_v <= sq_v - (sq_res + sq_bit);
                sq_res <= (sq_res >> 1) + sq_bit;
              end else begin
                sq_res <= sq_res >> 1;
              end
              sq_bit <= sq_bit >> 2;
              if (step == 6'd0) phase <= 3'd5;
              else step <= step - 6'd1;
            end
            default: begin
              inv <= sq_res[16:0];
              phase <= 3'd6;
              if (phase == 3'd6) begin
                r_q <= enc(sx, inv);
                g_q <= enc(sy, inv);
                b_q <= ((25'(inv) * 25'd255) >> 16) > 25'd255 ? 8'd255
                       : 8'(((25'(inv) * 25'd255) >> 16));
                state <= ST_OUT;
              end
            end
          endcase
        end
        ST_OUT: begin
          if (out_load) state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Output word register: frees the math while a finished word waits.
  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (out_load) begin
      o_valid <= 1'b1;
      o_red <= r_q;
      o_green <= g_q;
      o_blue <= b_q;
      o_last <= last_q;
    end else if (res_take) begin
      o_valid <= 1'b0;
    end
  end

  assign busy = state != ST_IDLE;
  assign res_valid = o_valid;
  assign red = o_red;
  assign green = o_green;
  assign blue = o_blue;
  assign res_last = o_last;

  `include "assert_macros.svh"
  `CHK_IMPL(a_no_new_busy, clk, rst, busy, !(state == ST_IDLE), "busy in idle")
  `CHK_NEXT(a_out_hold, clk, rst, res_valid && !res_take, res_valid, "result dropped")
endmodule
